// File: design/b58_pkg.sv
// Shared types, constants and character mapping functions for the Base58 codec.
// No dependencies; imported by every module of the codec.
`timescale 1ns / 1ps

package b58_pkg;

    localparam int BUF_DEPTH = 45;
    localparam int MAX_BYTES = 32;
    localparam int MAX_CHARS = 45;
    localparam int DIG_W     = 8;
    localparam int CNT_W     = 6;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int TOT_W     = CNT_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [IDX_W-1:0] TOP_IDX   = IDX_W'(BUF_DEPTH - 1);
    localparam logic [CNT_W-1:0] LIM_BYTES = CNT_W'(MAX_BYTES);
    localparam logic [CNT_W-1:0] LIM_CHARS = CNT_W'(MAX_CHARS);

    localparam logic [DIG_W-1:0] CHAR_ONE  = 8'h31;

    // Reciprocal of 58 scaled by 2^20; exact for dividends below 2^17.
    localparam int RECIP_SHIFT = 20;
    localparam logic [14:0] RECIP_58 = 15'd18079;

    localparam logic [0:0] REG_DIRECTION = 1'b0;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CHAR = 2'd1,
        ERR_LONG = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_FINISH,
        ST_EMIT_ERR,
        ST_EMIT_LEAD,
        ST_EMIT_DIGIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift_dn;
        logic shift_up;
    } cell_ctrl_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } char_val_t;

    function automatic char_val_t char_value(input logic [7:0] c);
        char_val_t r;
        r.ok  = 1'b1;
        r.val = '0;
        if (c inside {[8'h31:8'h39]}) begin
            r.val = 6'(c - 8'h31);
        end else if (c inside {[8'h41:8'h48]}) begin
            r.val = 6'(c - 8'h41 + 8'd9);
        end else if (c inside {[8'h4A:8'h4E]}) begin
            r.val = 6'(c - 8'h4A + 8'd17);
        end else if (c inside {[8'h50:8'h5A]}) begin
            r.val = 6'(c - 8'h50 + 8'd22);
        end else if (c inside {[8'h61:8'h6B]}) begin
            r.val = 6'(c - 8'h61 + 8'd33);
        end else if (c inside {[8'h6D:8'h7A]}) begin
            r.val = 6'(c - 8'h6D + 8'd44);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd9) begin
            return 8'h31 + w;
        end else if (v < 6'd17) begin
            return 8'h41 + w - 8'd9;
        end else if (v < 6'd22) begin
            return 8'h4A + w - 8'd17;
        end else if (v < 6'd33) begin
            return 8'h50 + w - 8'd22;
        end else if (v < 6'd44) begin
            return 8'h61 + w - 8'd33;
        end else begin
            return 8'h6D + w - 8'd44;
        end
    endfunction

endpackage

// File: design/b58_cell.sv
// One digit cell of the codec's digit chain; shifts towards either neighbour.
// Depends on b58_pkg for the control struct and digit width.
`timescale 1ns / 1ps

module b58_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  b58_pkg::cell_ctrl_t      ctrl,
    input  logic [b58_pkg::DIG_W-1:0] dn_in,
    input  logic [b58_pkg::DIG_W-1:0] up_in,
    output logic [b58_pkg::DIG_W-1:0] digit
);
    import b58_pkg::*;

    logic [DIG_W-1:0] digit_reg;
    logic [DIG_W-1:0] digit_next;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift_dn)
        begin
            digit_next = dn_in;
        end
        else if (ctrl.shift_up)
        begin
            digit_next = up_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

// File: design/b58_mac.sv
// Shared multiply-and-carry unit: folds one stored digit per cycle in base 58 or 256.
// Depends on b58_pkg for widths and the reciprocal constant.
`timescale 1ns / 1ps

module b58_mac (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic                     step,
    input  logic [b58_pkg::DIG_W-1:0] load_val,
    input  logic                     decoding,
    input  logic [b58_pkg::DIG_W-1:0] digit_in,
    output logic [b58_pkg::DIG_W-1:0] digit_out,
    output logic                     carry_nz,
    output logic                     carry_out_nz
);
    import b58_pkg::*;

    logic [DIG_W-1:0] carry_reg;
    logic [DIG_W-1:0] carry_next;
    logic [15:0]      dec_sum;
    logic [15:0]      enc_sum;
    logic [30:0]      prod;
    logic [10:0]      quot;
    logic [16:0]      quot58;
    logic [15:0]      rem;
    logic [DIG_W-1:0] step_carry;

    always_comb
    begin
        dec_sum    = 16'(carry_reg) + 16'(digit_in) * 16'd58;
        enc_sum    = {digit_in, 8'h00} + 16'(carry_reg);
        prod       = 31'(enc_sum) * 31'(RECIP_58);
        quot       = prod[30:RECIP_SHIFT];
        quot58     = (17'(quot) << 6) - (17'(quot) << 2) - (17'(quot) << 1);
        rem        = enc_sum - quot58[15:0];
        if (decoding)
        begin
            digit_out  = dec_sum[7:0];
            step_carry = dec_sum[15:8];
        end
        else
        begin
            digit_out  = rem[7:0];
            step_carry = quot[7:0];
        end
        carry_next = carry_reg;
        if (load)
        begin
            carry_next = load_val;
        end
        else if (step)
        begin
            carry_next = step_carry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    assign carry_nz     = (carry_reg != '0);
    assign carry_out_nz = (step_carry != '0);

endmodule

// File: design/base58_codec.sv
// Base58 codec top level: control, register port, digit chain and output register.
// Depends on b58_pkg, b58_cell and b58_mac.
// An element that is folded is accepted and then ripples its carry through the digit chain
// via the shared multiply-and-carry unit; a leading zero, a skipped element or an invalid
// character is accepted without folding. After the last element a check state runs, then
// one result per cycle while the output does not stall; unused top digits are shifted past.
// Reset clears the direction to encode and all message state.
`timescale 1ns / 1ps

module base58_codec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_elem,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_elem,
    output logic        out_last,
    output logic [1:0]  err_code
);
    import b58_pkg::*;

    state_t           state_reg, state_next;
    logic             direction_reg;
    logic [IDX_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] lead_reg, lead_next;
    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] elem_reg, elem_next;
    logic             bad_reg, bad_next;
    logic             ovf_reg, ovf_next;
    logic             last_pend_reg, last_pend_next;
    logic [IDX_W-1:0] pos_reg, pos_next;

    logic             out_valid_reg;
    logic [7:0]       out_elem_reg, out_elem_next;
    logic             out_last_reg, out_last_next;
    logic [1:0]       err_code_reg, err_code_next;
    logic             out_load;

    logic             cfg_wr;
    logic             msg_clear;
    cell_ctrl_t       cell_ctrl;
    logic [DIG_W-1:0] digits [BUF_DEPTH];
    logic [DIG_W-1:0] mac_digit;
    logic             mac_load;
    logic             mac_step;
    logic [DIG_W-1:0] mac_load_val;
    logic             carry_nz;
    logic             carry_out_nz;

    logic             accept;
    logic             slot_free;
    logic [CNT_W-1:0] in_limit;
    logic [TOT_W-1:0] out_limit;
    logic [TOT_W-1:0] total;
    char_val_t        cv;
    logic [DIG_W-1:0] v;
    logic             v_ok;
    err_t             err_sel;
    logic             emit_now;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_DIRECTION) ? {31'b0, direction_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
        end
        else if (cfg_wr && paddr[2] == REG_DIRECTION)
        begin
            direction_reg <= pwdata[0];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < BUF_DEPTH; gi++)
        begin : g_cell
            logic [DIG_W-1:0] dn_src;
            logic [DIG_W-1:0] up_src;
            if (gi == BUF_DEPTH - 1)
            begin : g_top
                assign dn_src = mac_digit;
            end
            else
            begin : g_mid
                assign dn_src = digits[gi + 1];
            end
            if (gi == 0)
            begin : g_bot
                assign up_src = digits[BUF_DEPTH - 1];
            end
            else
            begin : g_rest
                assign up_src = digits[gi - 1];
            end
            b58_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (cell_ctrl),
                .dn_in (dn_src),
                .up_in (up_src),
                .digit (digits[gi])
            );
        end
    endgenerate

    b58_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (mac_load),
        .step         (mac_step),
        .load_val     (mac_load_val),
        .decoding     (direction_reg),
        .digit_in     (digits[0]),
        .digit_out    (mac_digit),
        .carry_nz     (carry_nz),
        .carry_out_nz (carry_out_nz)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_limit  = direction_reg ? LIM_CHARS : LIM_BYTES;
    assign out_limit = direction_reg ? TOT_W'(LIM_BYTES) : TOT_W'(LIM_CHARS);
    assign total     = TOT_W'(lead_reg) + TOT_W'(used_reg);
    assign cv        = char_value(in_elem);
    assign v         = direction_reg ? {2'b00, cv.val} : in_elem;
    assign v_ok      = direction_reg ? cv.ok : 1'b1;
    assign err_sel   = bad_reg ? ERR_CHAR : ERR_LONG;
    assign emit_now  = (pos_reg < used_reg);

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        lead_next      = lead_reg;
        phase_next     = phase_reg;
        elem_next      = elem_reg;
        bad_next       = bad_reg;
        ovf_next       = ovf_reg;
        last_pend_next = last_pend_reg;
        pos_next       = pos_reg;
        out_load       = 1'b0;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        err_code_next  = err_code_reg;
        mac_load       = 1'b0;
        mac_step       = 1'b0;
        mac_load_val   = v;
        msg_clear      = 1'b0;
        cell_ctrl      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (elem_reg != CNT_MAX)
                    begin
                        elem_next = elem_reg + 1'b1;
                    end
                    if (in_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    if (!bad_reg && !ovf_reg && elem_next <= in_limit)
                    begin
                        if (!v_ok)
                        begin
                            bad_next = 1'b1;
                        end
                        else if (phase_reg && v == '0)
                        begin
                            if (lead_reg != CNT_MAX)
                            begin
                                lead_next = lead_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next     = 1'b0;
                            mac_load       = 1'b1;
                            pos_next       = '0;
                            last_pend_next = in_last;
                            state_next     = ST_FOLD;
                        end
                    end
                end
            end
            ST_FOLD:
            begin
                mac_step           = 1'b1;
                cell_ctrl.shift_dn = 1'b1;
                if (carry_nz && pos_reg >= used_reg)
                begin
                    used_next = pos_reg + 1'b1;
                end
                if (pos_reg == TOP_IDX)
                begin
                    if (carry_out_nz)
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = last_pend_reg ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (bad_reg || ovf_reg || elem_reg > in_limit || total > out_limit)
                begin
                    state_next = ST_EMIT_ERR;
                end
                else if (lead_reg != '0)
                begin
                    pos_next   = IDX_W'(lead_reg);
                    state_next = ST_EMIT_LEAD;
                end
                else if (used_reg != '0)
                begin
                    pos_next   = TOP_IDX;
                    state_next = ST_EMIT_DIGIT;
                end
                else
                begin
                    msg_clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_ERR:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_elem_next = '0;
                    out_last_next = 1'b1;
                    err_code_next = err_sel;
                    msg_clear     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_LEAD:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_elem_next = direction_reg ? 8'h00 : CHAR_ONE;
                    out_last_next = (pos_reg == IDX_W'(1)) && (used_reg == '0);
                    err_code_next = ERR_NONE;
                    pos_next      = pos_reg - 1'b1;
                    if (pos_reg == IDX_W'(1))
                    begin
                        if (used_reg != '0)
                        begin
                            pos_next   = TOP_IDX;
                            state_next = ST_EMIT_DIGIT;
                        end
                        else
                        begin
                            msg_clear  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_EMIT_DIGIT:
            begin
                if (!emit_now || slot_free)
                begin
                    cell_ctrl.shift_up = 1'b1;
                    if (emit_now)
                    begin
                        out_load      = 1'b1;
                        out_elem_next = direction_reg ? digits[BUF_DEPTH - 1]
                                                      : enc_char(digits[BUF_DEPTH - 1][5:0]);
                        out_last_next = (pos_reg == '0);
                        err_code_next = ERR_NONE;
                    end
                    if (pos_reg == '0)
                    begin
                        msg_clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr && paddr[2] == REG_DIRECTION)
        begin
            msg_clear = 1'b1;
        end

        if (msg_clear)
        begin
            used_next       = '0;
            lead_next       = '0;
            phase_next      = 1'b1;
            elem_next       = '0;
            bad_next        = 1'b0;
            ovf_next        = 1'b0;
            cell_ctrl.clear = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            lead_reg      <= '0;
            phase_reg     <= 1'b1;
            elem_reg      <= '0;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            last_pend_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            lead_reg      <= lead_next;
            phase_reg     <= phase_next;
            elem_reg      <= elem_next;
            bad_reg       <= bad_next;
            ovf_reg       <= ovf_next;
            last_pend_reg <= last_pend_next;
            pos_reg       <= pos_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_elem_reg <= out_elem_next;
            out_last_reg <= out_last_next;
            err_code_reg <= err_code_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_elem  = out_elem_reg;
    assign out_last  = out_last_reg;
    assign err_code  = err_code_reg;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for base58_codec: a directed table, then random messages in both
// directions, each result checked against a cycle-free Base58 conversion model held here.
// Depends on b58_pkg and the base58_codec RTL; needs no files or arguments.
`timescale 1ns / 1ps

module testbench;
    import b58_pkg::*;

    localparam int IDLE_PCT      = 27;
    localparam int SETTLE_CYCLES = 100;
    localparam int TAIL_CYCLES   = 100;
    localparam int LIMIT_CYCLES  = 500_000;
    localparam int RAND_ITEMS    = 100;
    localparam int PHASE_ITEMS   = 6;

    localparam logic [2:0] ADDR_DIRECTION = 3'(4 * REG_DIRECTION);
    localparam logic [2:0] ADDR_SPARE     = 3'd4;
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [8*58-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [7:0] elem;
        logic       last;
        err_t       err;
    } symbol_t;

    typedef enum logic [1:0] {
        ROW_ELEM,
        ROW_MODE,
        ROW_SPARE
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] elem;
        logic       last;
        logic       typed;
        symbol_t    want;
    } row_t;

    localparam symbol_t UNTYPED  = '{8'h00, 1'b0, ERR_NONE};
    localparam symbol_t BAD_CHAR = '{8'h00, 1'b1, ERR_CHAR};
    localparam symbol_t TOO_LONG = '{8'h00, 1'b1, ERR_LONG};

    localparam row_t PLAN [0:24] = '{
        '{ROW_ELEM,  8'h00, 1'b1, 1'b1, '{CHAR_ONE, 1'b1, ERR_NONE}},
        '{ROW_ELEM,  8'hFF, 1'b1, 1'b0, UNTYPED},
        '{ROW_ELEM,  8'h00, 1'b0, 1'b0, UNTYPED},
        '{ROW_ELEM,  8'h00, 1'b0, 1'b0, UNTYPED},
        '{ROW_ELEM,  8'h01, 1'b1, 1'b0, UNTYPED},
        '{ROW_ELEM,  8'h01, 1'b0, 1'b0, UNTYPED},
        '{ROW_ELEM,  8'h00, 1'b1, 1'b0, UNTYPED},
        '{ROW_ELEM,  8'h80, 1'b0, 1'b0, UNTYPED},
        '{ROW_MODE,  8'h01, 1'b0, 1'b0, UNTYPED},
        '{ROW_ELEM,  "1",   1'b1, 1'b1, '{8'h00, 1'b1, ERR_NONE}},
        '{ROW_ELEM,  "0",   1'b1, 1'b1, BAD_CHAR},
        '{ROW_ELEM,  "z",   1'b1, 1'b0, UNTYPED},
        '{ROW_ELEM,  "I",   1'b0, 1'b0, UNTYPED},
        '{ROW_ELEM,  "2",   1'b1, 1'b1, BAD_CHAR},
        '{ROW_ELEM,  "5",   1'b0, 1'b0, UNTYPED},
        '{ROW_ELEM,  "Q",   1'b1, 1'b0, UNTYPED},
        '{ROW_ELEM,  8'hFF, 1'b1, 1'b1, BAD_CHAR},
        '{ROW_ELEM,  8'h00, 1'b1, 1'b1, BAD_CHAR},
        '{ROW_ELEM,  "1",   1'b0, 1'b0, UNTYPED},
        '{ROW_ELEM,  "1",   1'b0, 1'b0, UNTYPED},
        '{ROW_ELEM,  "2",   1'b1, 1'b0, UNTYPED},
        '{ROW_SPARE, 8'h00, 1'b0, 1'b0, UNTYPED},
        '{ROW_ELEM,  "l",   1'b1, 1'b1, BAD_CHAR},
        '{ROW_MODE,  8'h00, 1'b0, 1'b0, UNTYPED},
        '{ROW_ELEM,  8'h80, 1'b1, 1'b0, UNTYPED}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_elem = '0;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_elem;
    logic        out_last;
    logic [1:0]  err_code;

    logic             cur_dir;
    logic [7:0]       acc_digits [BUF_DEPTH];
    logic [CNT_W-1:0] acc_used;
    logic [CNT_W-1:0] zero_run;
    logic [CNT_W-1:0] elem_seen;
    bit               in_zero_run;
    bit               bad_seen;
    bit               carry_out;

    symbol_t due[$];
    symbol_t burst[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      fed = 0;
    bit      calm = 1'b0;

    base58_codec i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_elem   (in_elem),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_elem  (out_elem),
        .out_last  (out_last),
        .err_code  (err_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] b58_char(input int k);
        return ALPHABET[8 * (57 - k) +: 8];
    endfunction

    function automatic int char_index(input logic [7:0] c);
        for (int k = 0; k < 58; k++)
        begin
            if (b58_char(k) == c)
                return k;
        end
        return -1;
    endfunction

    function automatic int input_cap();
        return cur_dir ? MAX_CHARS : MAX_BYTES;
    endfunction

    function automatic void clear_message();
        foreach (acc_digits[k])
            acc_digits[k] = 8'h00;
        acc_used    = '0;
        zero_run    = '0;
        elem_seen   = '0;
        in_zero_run = 1'b1;
        bad_seen    = 1'b0;
        carry_out   = 1'b0;
    endfunction

    // Multiply the stored number by the input radix and add the new digit, least
    // significant digit first: base 58 digits when encoding, bytes when decoding.
    function automatic void fold_value(input int v);
        int unsigned carry;
        int j;
        carry = v;
        j = 0;
        while (j < BUF_DEPTH && (carry != 0 || j < acc_used))
        begin
            if (cur_dir)
            begin
                carry += 58 * acc_digits[j];
                acc_digits[j] = 8'(carry);
                carry >>= 8;
            end
            else
            begin
                carry += 256 * acc_digits[j];
                acc_digits[j] = 8'(carry % 58);
                carry /= 58;
            end
            j++;
        end
        acc_used = CNT_W'(j);
        if (carry != 0)
            carry_out = 1'b1;
    endfunction

    function automatic void convert_element(input logic [7:0] e, input logic l);
        int v;
        int total;
        int out_cap;
        symbol_t s;
        logic [7:0] d;
        burst.delete();
        out_cap = cur_dir ? MAX_BYTES : MAX_CHARS;
        if (elem_seen != CNT_MAX)
            elem_seen++;
        if (!bad_seen && !carry_out && elem_seen <= input_cap())
        begin
            v = cur_dir ? char_index(e) : int'(e);
            if (v < 0)
                bad_seen = 1'b1;
            else if (in_zero_run && v == 0)
            begin
                if (zero_run != CNT_MAX)
                    zero_run++;
            end
            else
            begin
                in_zero_run = 1'b0;
                fold_value(v);
            end
        end
        if (!l)
            return;

        while (acc_used != 0 && acc_digits[acc_used - 1] == 8'h00)
            acc_used--;
        total = int'(zero_run) + int'(acc_used);

        if (bad_seen)
            burst = {burst, BAD_CHAR};
        else if (carry_out || elem_seen > input_cap() || total > out_cap || total > BUF_DEPTH)
            burst = {burst, TOO_LONG};
        else
        begin
            for (int k = 0; k < total; k++)
            begin
                if (k < zero_run)
                    s.elem = cur_dir ? 8'h00 : b58_char(0);
                else
                begin
                    d = acc_digits[total - 1 - k];
                    s.elem = cur_dir ? d : b58_char(d % 58);
                end
                s.last = (k == total - 1);
                s.err  = ERR_NONE;
                burst = {burst, s};
            end
        end
        clear_message();
    endfunction

    task automatic push_elem(input logic [7:0] e, input logic l);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_elem  <= e;
        in_last  <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic feed(input logic [7:0] e, input logic l, input bit typed, input symbol_t want);
        push_elem(e, l);
        convert_element(e, l);
        if (typed)
            due = {due, want};
        else
            due = {due, burst};
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DIRECTION)
        begin
            cur_dir = data[0];
            clear_message();
        end
    endtask

    task automatic reg_read(input logic [2:0] addr, output logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_mode();
        logic [31:0] rd;
        reg_read(ADDR_DIRECTION, rd);
        if (rd !== 32'(cur_dir))
        begin
            $display("%0t: direction readback expected %h, got %h", $time, 32'(cur_dir), rd);
            fail_count++;
        end
    endtask

    // The block may still be folding an element that produced no result, so give it time
    // to go idle once the last expected transaction has been seen.
    task automatic settle();
        in_valid <= 1'b0;
        while (due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic change_mode(input logic dir);
        settle();
        reg_write(ADDR_DIRECTION, 32'(dir));
        check_mode();
    endtask

    task automatic send_message(input int len);
        int lead;
        logic [7:0] e;
        lead = ($urandom_range(3) == 0) ? int'($urandom_range(len)) : 0;
        for (int i = 0; i < len; i++)
        begin
            if (i < lead)
                e = cur_dir ? CHAR_ONE : 8'h00;
            else if (cur_dir == DIR_ENCODE)
                e = 8'($urandom_range(255));
            else if ($urandom_range(29) == 0)
                e = 8'($urandom_range(255));
            else
                e = b58_char($urandom_range(57));
            feed(e, i == len - 1, 1'b0, UNTYPED);
            fed++;
        end
    endtask

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        symbol_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (due.size() == 0)
            begin
                $display("%0t: unexpected transaction, got elem %h last %b err %0d",
                         $time, out_elem, out_last, err_code);
                fail_count++;
            end
            else
            begin
                w = due.pop_front();
                if (out_elem !== w.elem || out_last !== w.last || err_code !== w.err)
                begin
                    $display("%0t: expected elem %h last %b err %0d, got elem %h last %b err %0d",
                             $time, w.elem, w.last, w.err, out_elem, out_last, err_code);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic first_dir;
        int quota;
        cur_dir = DIR_ENCODE;
        clear_message();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < $size(PLAN); r++)
        begin
            case (PLAN[r].kind)
                ROW_MODE:
                    change_mode(PLAN[r].elem[0]);
                ROW_SPARE:
                begin
                    settle();
                    reg_write(ADDR_SPARE, 32'(PLAN[r].elem));
                    check_mode();
                end
                default:
                    feed(PLAN[r].elem, PLAN[r].last, PLAN[r].typed, PLAN[r].want);
            endcase
        end

        // Alternate directions; the first two phases open with a message near or past the
        // input limit, the second one long enough to saturate the element counter.
        first_dir = 1'($urandom_range(1));
        for (int p = 0; p < 3 || fed < RAND_ITEMS; p++)
        begin
            change_mode(first_dir ^ p[0]);
            calm = (p == 2);
            quota = fed + PHASE_ITEMS;
            if (p == 0)
                send_message($urandom_range(input_cap() - 1, input_cap() + 3));
            if (p == 1)
                send_message(66);
            while (fed < quota)
            begin
                if ($urandom_range(11) == 0)
                    send_message($urandom_range(1, input_cap()));
                else
                    send_message($urandom_range(1, 10));
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
